// File: rtl/scld_pkg.sv
// package with the phase type, keyword codes and keyword tables of the command line decoder
`timescale 1ns / 1ps

package scld_pkg;

    localparam int RX_BYTE_W = 8;
    localparam int CODE_W    = 3;
    localparam int FLOOR_W   = 2;
    localparam int KW_W      = 3;
    localparam int POS_W     = 3;
    localparam int VALUE_W   = 3;

    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_DEAD      = 4'd1,
        PH_KEY       = 4'd2,
        PH_UNKNOWN   = 4'd3,
        PH_DONE      = 4'd4,
        PH_CALL_WS   = 4'd5,
        PH_CALL_SIGN = 4'd6,
        PH_CALL_DIG  = 4'd7,
        PH_CALL_END  = 4'd8
    } phase_t;

    localparam logic [KW_W-1:0] KW_HELP   = 3'd0;
    localparam logic [KW_W-1:0] KW_STATUS = 3'd1;
    localparam logic [KW_W-1:0] KW_RESUME = 3'd2;
    localparam logic [KW_W-1:0] KW_CALL   = 3'd3;
    localparam logic [KW_W-1:0] KW_NONE   = 3'd7;

    localparam logic [CODE_W-1:0] CMD_HELP      = 3'd0;
    localparam logic [CODE_W-1:0] CMD_STATUS    = 3'd1;
    localparam logic [CODE_W-1:0] CMD_RESUME    = 3'd2;
    localparam logic [CODE_W-1:0] CMD_CALL_OK   = 3'd3;
    localparam logic [CODE_W-1:0] CMD_CALL_FAIL = 3'd4;
    localparam logic [CODE_W-1:0] CMD_UNKNOWN   = 3'd5;

    localparam logic [RX_BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [RX_BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [RX_BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [RX_BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [RX_BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [RX_BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [RX_BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [RX_BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [RX_BYTE_W-1:0] CH_NUL   = 8'h00;

    // character of a keyword at a position, zero past its end
    function automatic logic [RX_BYTE_W-1:0] kw_char(input logic [KW_W-1:0] kw,
                                                     input logic [POS_W-1:0] pos);
        logic [RX_BYTE_W-1:0] ch;
        ch = CH_NUL;
        case ({kw, pos})
            {KW_HELP, 3'd0}:   ch = "H";
            {KW_HELP, 3'd1}:   ch = "E";
            {KW_HELP, 3'd2}:   ch = "L";
            {KW_HELP, 3'd3}:   ch = "P";
            {KW_STATUS, 3'd0}: ch = "S";
            {KW_STATUS, 3'd1}: ch = "T";
            {KW_STATUS, 3'd2}: ch = "A";
            {KW_STATUS, 3'd3}: ch = "T";
            {KW_STATUS, 3'd4}: ch = "U";
            {KW_STATUS, 3'd5}: ch = "S";
            {KW_RESUME, 3'd0}: ch = "R";
            {KW_RESUME, 3'd1}: ch = "E";
            {KW_RESUME, 3'd2}: ch = "S";
            {KW_RESUME, 3'd3}: ch = "U";
            {KW_RESUME, 3'd4}: ch = "M";
            {KW_RESUME, 3'd5}: ch = "E";
            {KW_CALL, 3'd0}:   ch = "C";
            {KW_CALL, 3'd1}:   ch = "A";
            {KW_CALL, 3'd2}:   ch = "L";
            {KW_CALL, 3'd3}:   ch = "L";
            default:           ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [POS_W-1:0] kw_len(input logic [KW_W-1:0] kw);
        logic [POS_W-1:0] len;
        case (kw)
            KW_HELP:   len = 3'd4;
            KW_STATUS: len = 3'd6;
            KW_RESUME: len = 3'd6;
            KW_CALL:   len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/scld_if.sv
// valid/ready channel interfaces for received bytes and decoded commands
`timescale 1ns / 1ps

interface scld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface scld_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command_code;
    logic [1:0] call_floor;

    modport source (output valid, output command_code, output call_floor, input ready);
    modport sink (input valid, input command_code, input call_floor, output ready);
endinterface

// File: rtl/serial_command_line_decoder_unit.sv
// serial command line decoder: on-the-fly keyword and CALL number parser
// usage:
//   rx carries one received character per transaction; cmd carries one
//   decoded command per line with a non-blank, non-NUL lead (command_code, call_floor)
//   bytes pass an input register, then one pass of decode logic updates the
//   parse state and loads the result register
//   a line-ending byte waits in the input register until cmd can take a
//   result, and its decoded command, if any, is then loaded into the result register
//   throughput: one byte per cycle while cmd does not stall, set by the single
//   decode pass between the input register and the result register
//   when cmd stalls, a byte waits in the input register and rx ready drops
//   only once both registers are full
//   reset clears both registers and puts the parser at the start of a line
//   lines longer than LINE_BUFFER_BYTES-1 characters drop the next byte and
//   restart decoding
`timescale 1ns / 1ps

module serial_command_line_decoder_unit
    import scld_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    scld_rx_if.sink           rx,
    scld_cmd_if.source        cmd
);

    localparam int CNT_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BUFFER_BYTES - 1);

    logic                 in_valid_reg;
    logic [RX_BYTE_W-1:0] in_byte_reg;

    logic [CNT_W-1:0]     line_count_reg, line_count_next;
    phase_t               phase_reg, phase_next;
    logic [KW_W-1:0]      cand_reg, cand_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 neg_reg, neg_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]    out_code_reg, out_code_next;
    logic [FLOOR_W-1:0]   out_floor_reg, out_floor_next;

    logic                 advance;
    logic                 emit;

    assign advance  = in_valid_reg && (!out_valid_reg || cmd.ready);
    assign rx.ready = !in_valid_reg || advance;

    assign cmd.valid        = out_valid_reg;
    assign cmd.command_code = out_code_reg;
    assign cmd.call_floor   = out_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // decode pass for the byte in the input register
    always_comb
    begin
        logic [RX_BYTE_W-1:0] c;
        logic [RX_BYTE_W-1:0] u;
        logic                 is_digit;
        logic [5:0]           acc;
        logic [POS_W-1:0]     pos_inc;

        c        = in_byte_reg;
        u        = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        acc      = 6'(value_reg) * 6'd10 + 6'(c - CH_ZERO);
        pos_inc  = pos_reg + 3'd1;

        line_count_next = line_count_reg;
        phase_next      = phase_reg;
        cand_next       = cand_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        neg_next        = neg_reg;
        emit            = 1'b0;
        out_code_next   = CMD_UNKNOWN;
        out_floor_next  = '0;

        if (c == CH_CR || c == CH_LF)
        begin
            if (line_count_reg != '0)
            begin
                case (phase_reg)
                    PH_LEAD, PH_DEAD:
                    begin
                        emit = 1'b0;
                    end
                    PH_DONE:
                    begin
                        emit          = 1'b1;
                        out_code_next = (cand_reg < KW_CALL) ? cand_reg : CMD_UNKNOWN;
                    end
                    PH_CALL_WS, PH_CALL_SIGN, PH_CALL_DIG, PH_CALL_END:
                    begin
                        emit = 1'b1;
                        if (!neg_reg && value_reg >= 3'd1 && value_reg <= 3'd3)
                        begin
                            out_code_next  = CMD_CALL_OK;
                            out_floor_next = value_reg[FLOOR_W-1:0];
                        end
                        else
                        begin
                            out_code_next = CMD_CALL_FAIL;
                        end
                    end
                    default:
                    begin
                        emit          = 1'b1;
                        out_code_next = CMD_UNKNOWN;
                    end
                endcase
                line_count_next = '0;
                phase_next      = PH_LEAD;
                cand_next       = KW_NONE;
                pos_next        = '0;
                value_next      = '0;
                neg_next        = 1'b0;
            end
        end
        else if (line_count_reg < CNT_LAST)
        begin
            line_count_next = line_count_reg + 1'b1;
            case (phase_reg)
                PH_LEAD:
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (c == CH_NUL)
                    begin
                        phase_next = PH_DEAD;
                    end
                    else if (u == kw_char(KW_HELP, 3'd0))
                    begin
                        cand_next  = KW_HELP;
                        pos_next   = 3'd1;
                        phase_next = PH_KEY;
                    end
                    else if (u == kw_char(KW_STATUS, 3'd0))
                    begin
                        cand_next  = KW_STATUS;
                        pos_next   = 3'd1;
                        phase_next = PH_KEY;
                    end
                    else if (u == kw_char(KW_RESUME, 3'd0))
                    begin
                        cand_next  = KW_RESUME;
                        pos_next   = 3'd1;
                        phase_next = PH_KEY;
                    end
                    else if (u == kw_char(KW_CALL, 3'd0))
                    begin
                        cand_next  = KW_CALL;
                        pos_next   = 3'd1;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        phase_next = PH_UNKNOWN;
                    end
                end
                PH_KEY:
                begin
                    if (cand_reg > KW_CALL || pos_reg > 3'd6)
                    begin
                        phase_next = PH_UNKNOWN;
                    end
                    else if (u != CH_NUL && u == kw_char(cand_reg, pos_reg))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= kw_len(cand_reg))
                        begin
                            phase_next = (cand_reg == KW_CALL) ? PH_CALL_WS : PH_DONE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_UNKNOWN;
                    end
                end
                PH_CALL_WS:
                begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    begin
                        phase_next = PH_CALL_WS;
                    end
                    else if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        neg_next   = (c == CH_MINUS);
                        phase_next = PH_CALL_SIGN;
                    end
                    else if (is_digit)
                    begin
                        value_next = (acc > 6'd4) ? 3'd4 : acc[VALUE_W-1:0];
                        phase_next = PH_CALL_DIG;
                    end
                    else
                    begin
                        phase_next = PH_CALL_END;
                    end
                end
                PH_CALL_SIGN, PH_CALL_DIG:
                begin
                    if (is_digit)
                    begin
                        value_next = (acc > 6'd4) ? 3'd4 : acc[VALUE_W-1:0];
                        phase_next = PH_CALL_DIG;
                    end
                    else
                    begin
                        phase_next = PH_CALL_END;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else
        begin
            // overlong line: drop this byte and restart
            line_count_next = '0;
            phase_next      = PH_LEAD;
            cand_next       = KW_NONE;
            pos_next        = '0;
            value_next      = '0;
            neg_next        = 1'b0;
        end
    end

    assign out_valid_next = advance ? emit : (out_valid_reg && !cmd.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            phase_reg      <= PH_LEAD;
            cand_reg       <= KW_NONE;
            pos_reg        <= '0;
            value_reg      <= '0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                line_count_reg <= line_count_next;
                phase_reg      <= phase_next;
                cand_reg       <= cand_next;
                pos_reg        <= pos_next;
                value_reg      <= value_next;
                neg_reg        <= neg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_code_reg  <= out_code_next;
            out_floor_reg <= out_floor_next;
        end
    end

endmodule
